// ===== sv/sslc_pkg.sv =====
package sslc_pkg;

  // Field and format widths
  localparam int SAMPLE_WIDTH = 24;
  localparam int COEF_WIDTH   = 32;
  localparam int STATE_W      = 32;
  localparam int ALPHA_W      = 31;
  localparam int ALPHA_FRAC   = 30;
  localparam int SFRAC        = SAMPLE_WIDTH - 1;
  localparam int CFRAC        = COEF_WIDTH - 4;

  // Saturator table geometry
  localparam int TANH_ENTRIES = 1024;
  localparam int TANH_BITS    = $clog2(TANH_ENTRIES);
  localparam int IFRAC        = SFRAC - TANH_BITS;
  localparam int IDX_W        = TANH_BITS + 1;

  // Shared multiplier and accumulator
  localparam int MUL_W  = (COEF_WIDTH > STATE_W) ? COEF_WIDTH : STATE_W;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 3;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (COEF_WIDTH > ALPHA_W) ? COEF_WIDTH : ALPHA_W;

  localparam logic [CFG_IDX_W-1:0] REG_B0     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_B1     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_B2     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_A1     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_A2     = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS = CFG_IDX_W'(6);

  // Sequencer steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_SHELF = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(15);

  typedef enum logic [3:0] {
    MS_NONE, MS_TANH, MS_B0, MS_B1, MS_B2, MS_A1, MS_A2, MS_LP_Y, MS_LP_L
  } mul_sel_t;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_ROM_LO, ACT_ROM_HI, ACT_DIFF, ACT_TANH, ACT_BIQUAD, ACT_LOWPASS
  } act_t;

  typedef enum logic [1:0] {JMP_NONE, JMP_NO_SAT, JMP_DONE} jmp_t;

  typedef struct packed {
    mul_sel_t            mul_sel;
    acc_op_t             acc_op;
    act_t                act;
    jmp_t                jmp;
    logic [STEP_W-1:0]   target;
  } uword_t;

  typedef logic signed [SAMPLE_WIDTH-1:0] tanh_rom_t [0:TANH_ENTRIES];

  // Microprogram: saturator (steps 0-4), biquad (5-11), lowpass (12-15).
  // A multiplier result is registered in the product register before a later step reads it.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{mul_sel: MS_NONE, acc_op: ACC_HOLD, act: ACT_NONE, jmp: JMP_NONE,
          target: STEP_FIRST};
    unique case (step)
      4'd0: begin
        w.act    = ACT_ROM_LO;
        w.jmp    = JMP_NO_SAT;
        w.target = STEP_SHELF;
      end
      4'd1:  w.act = ACT_ROM_HI;
      4'd2:  w.act = ACT_DIFF;
      4'd3:  w.mul_sel = MS_TANH;
      4'd4:  w.act = ACT_TANH;
      4'd5:  w.mul_sel = MS_B0;
      4'd6: begin
        w.mul_sel = MS_B1;
        w.acc_op  = ACC_LOAD;
      end
      4'd7: begin
        w.mul_sel = MS_B2;
        w.acc_op  = ACC_ADD;
      end
      4'd8: begin
        w.mul_sel = MS_A1;
        w.acc_op  = ACC_ADD;
      end
      4'd9: begin
        w.mul_sel = MS_A2;
        w.acc_op  = ACC_SUB;
      end
      4'd10: w.acc_op = ACC_SUB;
      4'd11: w.act = ACT_BIQUAD;
      4'd12: w.mul_sel = MS_LP_Y;
      4'd13: begin
        w.mul_sel = MS_LP_L;
        w.acc_op  = ACC_LOAD;
      end
      4'd14: w.acc_op = ACC_ADD;
      4'd15: begin
        w.act = ACT_LOWPASS;
        w.jmp = JMP_DONE;
      end
      default: w.act = ACT_NONE;
    endcase
    return w;
  endfunction

  // Restoring long division for table construction (elaboration only)
  function automatic longint unsigned udiv64(
    input longint unsigned n,
    input longint unsigned d
  );
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(1.05*i/N) points in sample format, from a Q30 exp series (elaboration only)
  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t         rom;
    longint unsigned   z, sum, term, d, q, t30, v;
    logic              stop;
    for (int i = 0; i <= TANH_ENTRIES; i++) begin
      z    = udiv64((64'd21 * longint'(i)) << 30, 64'd10 * longint'(TANH_ENTRIES));
      sum  = 64'd1 << 30;
      term = 64'd1 << 30;
      stop = 1'b0;
      for (int k = 1; k <= 40; k++) begin
        if (!stop) begin
          term = udiv64((term * z) >> 30, longint'(k));
          if (term == 64'd0) begin
            stop = 1'b1;
          end else begin
            sum = sum + term;
          end
        end
      end
      d   = sum + (64'd1 << 30);
      q   = udiv64((64'd1 << 61) + (d >> 1), d);
      t30 = (64'd1 << 30) - q;
      v   = ((t30 << 2) + (64'd1 << (32 - SAMPLE_WIDTH))) >> (33 - SAMPLE_WIDTH);
      rom[i] = v[SAMPLE_WIDTH-1:0];
    end
    return rom;
  endfunction

  // Clamp an accumulator-wide value to the signed state range
  function automatic logic signed [STATE_W-1:0] sat_state(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'((longint'(1) <<< (STATE_W - 1)) - 1);
    lo = -ACC_W'(longint'(1) <<< (STATE_W - 1));
    if (v > hi) begin
      return hi[STATE_W-1:0];
    end else if (v < lo) begin
      return lo[STATE_W-1:0];
    end
    return v[STATE_W-1:0];
  endfunction

endpackage

// ===== sv/sslc_if.sv =====
interface sslc_in_if;
  import sslc_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           dry_path;

  modport source (output valid, sample_in, dry_path, input ready);
  modport sink   (input valid, sample_in, dry_path, output ready);
endinterface

interface sslc_out_if;
  import sslc_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           clipped;

  modport source (output valid, sample_out, clipped, input ready);
  modport sink   (input valid, sample_out, clipped, output ready);
endinterface

// ===== sv/saturator_shelf_lowpass_chain_core.sv =====
// Saturating high-shelf biquad and one-pole lowpass, two independent paths.
// in_chan carries one word: a 24-bit sample and a path flag (0 wet, 1 dry).
// The wet path runs a tanh(1.05x) table saturator first unless the bypass
// register is set. out_chan carries the filtered, range-clamped sample and a
// flag that is high when the clamp acted.
// cfg_we/cfg_index/cfg_data write the five shelf coefficients, the lowpass
// alpha and the saturator bypass; write them only while no word is in flight.
// out_chan.valid rises at the edge that completes the last step, and the
// input is ready again at that same edge, so a new word is taken only once
// the previous one is done; the dry or bypassed path skips the saturator
// steps. The single shared 32x32 multiplier sets the pace: seven products per
// word, eight with the saturator, walked through by a 16-step microprogram,
// plus two table reads for the saturator.
// Reset sets b0 to 1.0 and all other configuration registers and both paths'
// filter state to zero; the saturator table is a constant ROM and needs no fill.
// A result waits in the output register while the receiver stalls; the next
// word is still accepted and computed, and holds at its last step until the
// output register frees up.
module saturator_shelf_lowpass_chain_core (
  input  logic                               clk,
  input  logic                               rst_n,
  sslc_in_if.sink                            in_chan,
  sslc_out_if.source                         out_chan,
  input  logic                               cfg_we,
  input  logic [sslc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sslc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sslc_pkg::*;

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(longint'(1) << ALPHA_FRAC);
  localparam logic signed [PROD_W-1:0] RND_I = PROD_W'(longint'(1) << (IFRAC - 1));
  localparam logic signed [ACC_W-1:0]  RND_C = ACC_W'(longint'(1) << (CFRAC - 1));
  localparam logic signed [ACC_W-1:0]  RND_A = ACC_W'(longint'(1) << (ALPHA_FRAC - 1));
  localparam logic signed [STATE_W-1:0] SAMP_MAX = STATE_W'((longint'(1) << SFRAC) - 1);
  localparam logic signed [STATE_W-1:0] SAMP_MIN = -STATE_W'(longint'(1) << SFRAC);
  localparam logic [IDX_W-1:0] IDX_END = IDX_W'(TANH_ENTRIES);

  // Configuration registers
  logic signed [COEF_WIDTH-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic [ALPHA_W-1:0]           alpha_r;
  logic                         bypass_r;

  // Per-path filter state (index 0 wet, 1 dry)
  logic signed [STATE_W-1:0] pi1_r [2];
  logic signed [STATE_W-1:0] pi2_r [2];
  logic signed [STATE_W-1:0] po1_r [2];
  logic signed [STATE_W-1:0] po2_r [2];
  logic signed [STATE_W-1:0] lvl_r [2];

  // Sequencer
  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  uword_t            uw;
  logic              out_stall;
  logic              advance;

  // Datapath registers
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic                           path_r;
  logic                           sat_en_r;
  logic signed [SAMPLE_WIDTH-1:0] rom_q_r;
  logic signed [SAMPLE_WIDTH-1:0] pt0_r;
  logic signed [SAMPLE_WIDTH:0]   diff_r;
  logic signed [PROD_W-1:0]       prod_r;
  logic signed [ACC_W-1:0]        acc_r;

  // Output register
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                           out_clip_r;

  // Combinational datapath values
  logic [SAMPLE_WIDTH-1:0]        mag;
  logic [IDX_W-1:0]               idx_lo;
  logic [IDX_W-1:0]               idx_hi;
  logic [IDX_W-1:0]               rom_addr;
  logic signed [MUL_W-1:0]        mul_a;
  logic signed [MUL_W-1:0]        mul_b;
  logic [ALPHA_W-1:0]             alpha_cl;
  logic [ALPHA_W-1:0]             alpha_inv;
  logic signed [PROD_W-1:0]       tanh_rnd;
  logic signed [SAMPLE_WIDTH:0]   tanh_pos;
  logic signed [SAMPLE_WIDTH:0]   tanh_val;
  logic signed [STATE_W-1:0]      bq_y;
  logic signed [STATE_W-1:0]      lp_v;
  logic signed [SAMPLE_WIDTH-1:0] res_sample;
  logic                           res_clip;

  assign in_chan.ready       = !busy_r;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_sample_r;
  assign out_chan.clipped    = out_clip_r;

  // Decode the current control word and pick the next step
  assign uw        = ucode(step_r);
  assign out_stall = busy_r && (uw.act == ACT_LOWPASS) && out_valid_r && !out_chan.ready;
  assign advance   = busy_r && !out_stall;

  always_comb begin
    step_nxt = step_r + STEP_W'(1);
    if (uw.jmp == JMP_NO_SAT && !sat_en_r) begin
      step_nxt = uw.target;
    end
  end

  // Table addressing from the sample magnitude
  assign mag      = x_r[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-x_r) : SAMPLE_WIDTH'(x_r);
  assign idx_lo   = mag[SAMPLE_WIDTH-1:IFRAC];
  assign idx_hi   = (idx_lo == IDX_END) ? idx_lo : idx_lo + IDX_W'(1);
  assign rom_addr = (uw.act == ACT_ROM_HI) ? idx_hi : idx_lo;

  // Interpolate and restore the sign
  assign tanh_rnd = (prod_r + RND_I) >>> IFRAC;
  assign tanh_pos = $signed({pt0_r[SAMPLE_WIDTH-1], pt0_r}) +
                    $signed(tanh_rnd[SAMPLE_WIDTH:0]);
  assign tanh_val = x_r[SAMPLE_WIDTH-1] ? -tanh_pos : tanh_pos;

  // Lowpass weights, alpha clamped to one
  assign alpha_cl  = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign alpha_inv = ALPHA_ONE - alpha_cl;

  // Round and clamp the accumulator for the biquad and the lowpass
  assign bq_y = sat_state((acc_r + RND_C) >>> CFRAC);
  assign lp_v = sat_state((acc_r + RND_A) >>> ALPHA_FRAC);

  always_comb begin
    res_clip   = 1'b0;
    res_sample = lp_v[SAMPLE_WIDTH-1:0];
    if (lp_v > SAMP_MAX) begin
      res_clip   = 1'b1;
      res_sample = SAMP_MAX[SAMPLE_WIDTH-1:0];
    end else if (lp_v < SAMP_MIN) begin
      res_clip   = 1'b1;
      res_sample = SAMP_MIN[SAMPLE_WIDTH-1:0];
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (uw.mul_sel)
      MS_TANH: begin
        mul_a = MUL_W'(diff_r);
        mul_b = MUL_W'($signed({1'b0, mag[IFRAC-1:0]}));
      end
      MS_B0: begin
        mul_a = MUL_W'(b0_r);
        mul_b = MUL_W'(x_r);
      end
      MS_B1: begin
        mul_a = MUL_W'(b1_r);
        mul_b = MUL_W'(pi1_r[path_r]);
      end
      MS_B2: begin
        mul_a = MUL_W'(b2_r);
        mul_b = MUL_W'(pi2_r[path_r]);
      end
      MS_A1: begin
        mul_a = MUL_W'(a1_r);
        mul_b = MUL_W'(po1_r[path_r]);
      end
      MS_A2: begin
        mul_a = MUL_W'(a2_r);
        mul_b = MUL_W'(po2_r[path_r]);
      end
      MS_LP_Y: begin
        mul_a = MUL_W'($signed({1'b0, alpha_inv}));
        mul_b = MUL_W'(po1_r[path_r]);
      end
      MS_LP_L: begin
        mul_a = MUL_W'($signed({1'b0, alpha_cl}));
        mul_b = MUL_W'(lvl_r[path_r]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Read the saturator ROM and register the product
  always_ff @(posedge clk) begin
    rom_q_r <= TANH_ROM[rom_addr];
    prod_r  <= mul_a * mul_b;
  end

  // Advance the step counter; take a new word when idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_FIRST;
    end else if (!busy_r) begin
      if (in_chan.valid) begin
        busy_r <= 1'b1;
        step_r <= STEP_FIRST;
      end
    end else if (advance) begin
      if (uw.jmp == JMP_DONE) begin
        busy_r <= 1'b0;
      end
      step_r <= step_nxt;
    end
  end

  // Latch the word, run the saturator steps and the accumulator
  always_ff @(posedge clk) begin
    if (!busy_r && in_chan.valid) begin
      x_r      <= in_chan.sample_in;
      path_r   <= in_chan.dry_path;
      sat_en_r <= !in_chan.dry_path && !bypass_r;
    end else if (advance) begin
      case (uw.act)
        ACT_ROM_HI: pt0_r <= rom_q_r;
        ACT_DIFF:   diff_r <= $signed({rom_q_r[SAMPLE_WIDTH-1], rom_q_r}) -
                              $signed({pt0_r[SAMPLE_WIDTH-1], pt0_r});
        ACT_TANH:   x_r <= tanh_val[SAMPLE_WIDTH-1:0];
        default:    ;
      endcase
      case (uw.acc_op)
        ACC_LOAD: acc_r <= ACC_W'(prod_r);
        ACC_ADD:  acc_r <= acc_r + ACC_W'(prod_r);
        ACC_SUB:  acc_r <= acc_r - ACC_W'(prod_r);
        default:  ;
      endcase
    end
  end

  // Configuration writes and filter state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r     <= COEF_WIDTH'(longint'(1) << CFRAC);
      b1_r     <= '0;
      b2_r     <= '0;
      a1_r     <= '0;
      a2_r     <= '0;
      alpha_r  <= '0;
      bypass_r <= 1'b0;
      for (int p = 0; p < 2; p++) begin
        pi1_r[p] <= '0;
        pi2_r[p] <= '0;
        po1_r[p] <= '0;
        po2_r[p] <= '0;
        lvl_r[p] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_B0:     b0_r     <= cfg_data[COEF_WIDTH-1:0];
          REG_B1:     b1_r     <= cfg_data[COEF_WIDTH-1:0];
          REG_B2:     b2_r     <= cfg_data[COEF_WIDTH-1:0];
          REG_A1:     a1_r     <= cfg_data[COEF_WIDTH-1:0];
          REG_A2:     a2_r     <= cfg_data[COEF_WIDTH-1:0];
          REG_ALPHA:  alpha_r  <= cfg_data[ALPHA_W-1:0];
          REG_BYPASS: bypass_r <= cfg_data[0];
          default:    ;
        endcase
      end
      if (advance && uw.act == ACT_BIQUAD) begin
        pi2_r[path_r] <= pi1_r[path_r];
        pi1_r[path_r] <= STATE_W'(x_r);
        po2_r[path_r] <= po1_r[path_r];
        po1_r[path_r] <= bq_y;
      end
      if (advance && uw.act == ACT_LOWPASS) begin
        lvl_r[path_r] <= lp_v;
      end
    end
  end

  // Output register: load on the last step, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && uw.act == ACT_LOWPASS) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && uw.act == ACT_LOWPASS) begin
      out_sample_r <= res_sample;
      out_clip_r   <= res_clip;
    end
  end

  // An accepted word starts the program at its first step
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (busy_r && step_r == STEP_FIRST))
    else $error("accepted word did not start the microprogram");

  // The dry or bypassed path never runs the saturator steps
  a_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !sat_en_r) |-> (step_r == STEP_FIRST || step_r >= STEP_SHELF))
    else $error("saturator step executed without saturation");

  // Finishing the last step posts a result and frees the input
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && step_r == STEP_LAST && !out_stall) |=> (out_valid_r && !busy_r))
    else $error("last step did not post a result");

  // A clipped result sits at one of the range limits
  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_clip_r) |->
      (out_sample_r == SAMP_MAX[SAMPLE_WIDTH-1:0] ||
       out_sample_r == SAMP_MIN[SAMPLE_WIDTH-1:0]))
    else $error("clipped flag without a limit value");

endmodule

// ===== sim/saturator_shelf_lowpass_chain_core_tb.sv =====
module saturator_shelf_lowpass_chain_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sslc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);
  localparam logic [CFG_IDX_W-1:0] REG_ORDER [8] = '{
    REG_B0, REG_B1, REG_B2, REG_A1, REG_A2, REG_ALPHA, REG_BYPASS, REG_UNUSED
  };
  localparam longint ALPHA_UNITY = 64'sd1 << 30;
  localparam longint SAMPLE_MAX  = (64'sd1 <<< SFRAC) - 1;
  localparam longint SAMPLE_MIN  = -(64'sd1 <<< SFRAC);
  localparam logic [31:0] COEF_UNITY = 32'h1000_0000;

  typedef struct {
    logic signed [31:0] b0;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic [31:0]        alpha_word;
    logic [31:0]        bypass_word;
    logic [31:0]        spare_word;
  } shelf_regs_t;

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           clipped;
  } shelf_result_t;

  logic clk = 1'b0;
  logic rst_n;

  sslc_in_if  in_chan ();
  sslc_out_if out_chan ();

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  saturator_shelf_lowpass_chain_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor copy of registers, filter history and saturator curve
  shelf_regs_t   active_regs;
  longint        tanh_curve [0:TANH_ENTRIES];
  longint        hist_in_one [2];
  longint        hist_in_two [2];
  longint        hist_out_one [2];
  longint        hist_out_two [2];
  longint        smooth_level [2];
  shelf_result_t pending_outputs [$];

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_request   = 0;
  int hold_left      = 0;

  // Fill the tanh(1.05x) curve from a Q30 exp series, rounded to sample format
  function automatic void fill_tanh_curve();
    longint unsigned z, sum, term, den, quot, t30;
    for (int i = 0; i <= TANH_ENTRIES; i++) begin
      z    = ((64'd21 * 64'(i)) << 30) / (64'd10 * 64'(TANH_ENTRIES));
      sum  = 64'd1 << 30;
      term = 64'd1 << 30;
      for (int k = 1; k <= 40; k++) begin
        term = ((term * z) >> 30) / 64'(k);
        if (term == 0) break;
        sum += term;
      end
      den  = sum + (64'd1 << 30);
      quot = ((64'd1 << 61) + den / 2) / den;
      t30  = (64'd1 << 30) - quot;
      tanh_curve[i] = longint'(((t30 << 2) + (64'd1 << (32 - SAMPLE_WIDTH)))
                               >> (33 - SAMPLE_WIDTH));
    end
  endfunction

  // Odd-symmetric table lookup with linear interpolation, rounded half up
  function automatic longint soft_clip(input longint x);
    longint mag, pos, idx, frac, y;
    mag  = (x < 0) ? -x : x;
    pos  = mag * TANH_ENTRIES;
    idx  = pos >>> SFRAC;
    frac = pos & ((64'sd1 <<< SFRAC) - 1);
    if (idx >= TANH_ENTRIES) begin
      y = tanh_curve[TANH_ENTRIES];
    end else begin
      y = tanh_curve[idx] +
          (((tanh_curve[idx + 1] - tanh_curve[idx]) * frac + (64'sd1 <<< (SFRAC - 1)))
           >>> SFRAC);
    end
    return (x < 0) ? -y : y;
  endfunction

  // Compute the next output word for one path and advance its history
  function automatic shelf_result_t predict_shelf_output(
    input logic signed [SAMPLE_WIDTH-1:0] sample,
    input logic                           dry
  );
    shelf_result_t      r;
    longint             x, y, alpha, lp;
    logic signed [95:0] acc;
    int                 p;
    p = dry ? 1 : 0;
    x = longint'(sample);
    if (!dry && !active_regs.bypass_word[0]) x = soft_clip(x);

    acc = active_regs.b0 * x + active_regs.b1 * hist_in_one[p]
        + active_regs.b2 * hist_in_two[p] - active_regs.a1 * hist_out_one[p]
        - active_regs.a2 * hist_out_two[p];
    acc = (acc + (96'sd1 <<< (CFRAC - 1))) >>> CFRAC;
    if (acc > 96'sd2147483647) acc = 96'sd2147483647;
    if (acc < -96'sd2147483648) acc = -96'sd2147483648;
    y = longint'(acc);

    hist_in_two[p]  = hist_in_one[p];
    hist_in_one[p]  = x;
    hist_out_two[p] = hist_out_one[p];
    hist_out_one[p] = y;

    // Clamp alpha at one, then blend with the held level
    alpha = longint'(active_regs.alpha_word[ALPHA_W-1:0]);
    if (alpha > ALPHA_UNITY) alpha = ALPHA_UNITY;
    lp = ((ALPHA_UNITY - alpha) * y + alpha * smooth_level[p] + (64'sd1 <<< 29)) >>> 30;
    if (lp > 64'sd2147483647) lp = 64'sd2147483647;
    if (lp < -64'sd2147483648) lp = -64'sd2147483648;
    smooth_level[p] = lp;

    r.clipped = 1'b0;
    if (lp > SAMPLE_MAX) begin
      lp = SAMPLE_MAX;
      r.clipped = 1'b1;
    end
    if (lp < SAMPLE_MIN) begin
      lp = SAMPLE_MIN;
      r.clipped = 1'b1;
    end
    r.sample_out = SAMPLE_WIDTH'(lp);
    return r;
  endfunction

  // Predict each accepted input word
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) begin
      pending_outputs.push_back(predict_shelf_output(in_chan.sample_in, in_chan.dry_path));
    end
  end

  // Compare each accepted output word against the oldest prediction
  always @(posedge clk) begin
    shelf_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected output word: sample_out %0d clipped %0b",
               out_chan.sample_out, out_chan.clipped);
        mismatch_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_chan.sample_out !== want.sample_out) begin
          $error("sample_out mismatch: expected %0d, got %0d",
                 want.sample_out, out_chan.sample_out);
          mismatch_count++;
        end
        if (out_chan.clipped !== want.clipped) begin
          $error("clipped mismatch: expected %0b, got %0b", want.clipped, out_chan.clipped);
          mismatch_count++;
        end
      end
    end
  end

  // Drive ready: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one word after an optional gap; return at the accepting edge
  task automatic send_word(input logic signed [SAMPLE_WIDTH-1:0] value, input logic dry);
    if ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid     <= 1'b0;
      in_chan.sample_in <= SAMPLE_WIDTH'($urandom);
      in_chan.dry_path  <= 1'($urandom);
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_chan.valid     <= 1'b1;
    in_chan.sample_in <= value;
    in_chan.dry_path  <= dry;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (pending_outputs.size() != 0);
    @(posedge clk);
  endtask

  // Write every register, plus the unused index, while the block is idle
  task automatic load_regs(input shelf_regs_t regs);
    logic [31:0] data;
    foreach (REG_ORDER[i]) begin
      case (REG_ORDER[i])
        REG_B0:     data = regs.b0;
        REG_B1:     data = regs.b1;
        REG_B2:     data = regs.b2;
        REG_A1:     data = regs.a1;
        REG_A2:     data = regs.a2;
        REG_ALPHA:  data = regs.alpha_word;
        REG_BYPASS: data = regs.bypass_word;
        default:    data = regs.spare_word;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data  <= CFG_DATA_W'(data);
      @(posedge clk);
    end
    cfg_we      <= 1'b0;
    active_regs  = regs;
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
    if ($urandom_range(99) < 30) begin
      return SAMPLE_WIDTH'(int'($urandom_range(8192)) - 4096);
    end
    return SAMPLE_WIDTH'($urandom);
  endfunction

  function automatic logic [31:0] random_alpha_word();
    case ($urandom_range(5))
      0:       return 32'h0;
      1:       return 32'h4000_0000;
      2:       return $urandom;
      default: return $urandom_range(32'h4000_0000);
    endcase
  endfunction

  // Stable, moderate-gain shelf or fully random coefficients
  function automatic shelf_regs_t random_regs(input bit wild);
    shelf_regs_t r;
    if (wild) begin
      r.b0 = $urandom;
      r.b1 = $urandom;
      r.b2 = $urandom;
      r.a1 = $urandom;
      r.a2 = $urandom;
    end else begin
      r.b0 = $urandom_range(32'h2800_0000, 32'h0800_0000);
      r.b1 = int'($urandom_range(32'h1000_0000)) - 32'sh0800_0000;
      r.b2 = int'($urandom_range(32'h1000_0000)) - 32'sh0800_0000;
      r.a1 = int'($urandom_range(32'h0CCC_CCCC)) - 32'sh0666_6666;
      r.a2 = int'($urandom_range(32'h1000_0000)) - 32'sh0800_0000;
    end
    r.alpha_word  = random_alpha_word();
    r.bypass_word = $urandom;
    r.spare_word  = $urandom;
    return r;
  endfunction

  // Defaults after reset: unity shelf, no smoothing, saturator active
  task automatic test_reset_defaults();
    send_word(24'sd0, 1'b0);
    send_word(24'sh7F_FFFF, 1'b0);
    send_word(-24'sh80_0000, 1'b0);
    send_word(24'sd1, 1'b0);
    send_word(-24'sd1, 1'b0);
    send_word(24'sd4096, 1'b0);
    send_word(24'sd8192, 1'b0);
    send_word(24'sh40_0000, 1'b0);
    send_word(24'sh7F_FFFF, 1'b1);
    send_word(-24'sh80_0000, 1'b1);
    send_word(24'sd0, 1'b1);
    wait_drained();
  endtask

  // Coefficient and alpha extremes, masked high bits, unused register index
  task automatic test_register_extremes();
    load_regs('{b0: 32'sh7FFF_FFFF, b1: 0, b2: 0, a1: 0, a2: 0,
                alpha_word: 0, bypass_word: 32'h1, spare_word: 32'hFFFF_FFFF});
    send_word(24'sh7F_FFFF, 1'b0);
    send_word(-24'sh80_0000, 1'b0);
    send_word(24'sh7F_FFFF, 1'b1);
    send_word(24'sd100, 1'b0);
    wait_drained();

    load_regs('{b0: 32'sh8000_0000, b1: 32'sh7FFF_FFFF, b2: 32'sh8000_0000,
                a1: 32'sh7FFF_FFFF, a2: 32'sh8000_0000, alpha_word: 32'h4000_0000,
                bypass_word: 32'hFFFF_FFFE, spare_word: 32'h0});
    send_word(24'sh7F_FFFF, 1'b0);
    send_word(-24'sh80_0000, 1'b0);
    send_word(24'sh7F_FFFF, 1'b0);
    send_word(-24'sh80_0000, 1'b1);
    send_word(24'sh7F_FFFF, 1'b1);
    wait_drained();

    load_regs('{b0: COEF_UNITY, b1: 0, b2: 0, a1: 0, a2: 0,
                alpha_word: 32'hFFFF_FFFF, bypass_word: 32'h0, spare_word: $urandom});
    send_word(24'sh7F_FFFF, 1'b0);
    send_word(-24'sh12_3456, 1'b1);
    send_word(24'sd0, 1'b0);
    wait_drained();
  endtask

  // Random words across several register settings and idling patterns
  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      load_regs(random_regs(phase % 3 == 2));
      for (int n = 0; n < 240; n++) begin
        send_word(random_sample(), 1'($urandom));
      end
      wait_drained();
    end
  endtask

  // Hold the output off for a long stretch while words keep arriving
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 20;
    load_regs(random_regs(1'b0));
    @(negedge clk);
    hold_request = 400;
    @(posedge clk);
    for (int n = 0; n < 16; n++) begin
      send_word(random_sample(), 1'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.sample_in <= '0;
    in_chan.dry_path  <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_B0;
    cfg_data          <= '0;

    fill_tanh_curve();
    active_regs = '{b0: COEF_UNITY, b1: 0, b2: 0, a1: 0, a2: 0,
                    alpha_word: 0, bypass_word: 0, spare_word: 0};
    for (int p = 0; p < 2; p++) begin
      hist_in_one[p]  = 0;
      hist_in_two[p]  = 0;
      hist_out_one[p] = 0;
      hist_out_two[p] = 0;
      smooth_level[p] = 0;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_random_settings();
    test_output_backpressure();

    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_outputs.size() == 0) begin
      $display("saturator_shelf_lowpass_chain_core_tb: PASS");
    end else begin
      $display("saturator_shelf_lowpass_chain_core_tb: FAIL");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #10ms;
    $display("saturator_shelf_lowpass_chain_core_tb: FAIL");
    $finish;
  end

endmodule
